// ----- sv/fvc_pkg.sv -----
// shared constants, types and codes for the frustum volume culler
package fvc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int FRAC_BITS   = 16;

  localparam int COORD_W = 32;
  localparam int SLOT_W  = 3;
  localparam int CMD_W   = 2;
  localparam int VIS_W   = 2;
  localparam int IDX_W   = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int OP_W    = COORD_W + 1;
  localparam int ACC_W   = 2 * OP_W - FRAC_BITS + 3;
  localparam int TERM_W  = 3;
  localparam int AXES    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_BOX    = 2'd3
  } cmd_t;

  localparam logic [VIS_W-1:0] VIS_INVISIBLE = 2'd0;
  localparam logic [VIS_W-1:0] VIS_PARTIAL   = 2'd1;
  localparam logic [VIS_W-1:0] VIS_FULL      = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INIT = 5'b00010,
    S_MUL  = 5'b00100,
    S_ADD  = 5'b01000,
    S_CMP  = 5'b10000
  } state_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OP_W-1:0]    oper_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

endpackage

// ----- sv/fvc_if.sv -----
// valid/ready channel interfaces for commands and visibility results
interface fvc_cmd_if;
  import fvc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [SLOT_W-1:0]   plane_slot;
  coord_t              first_x;
  coord_t              first_y;
  coord_t              first_z;
  coord_t              second_x;
  coord_t              second_y;
  coord_t              second_z;
  coord_t              scalar_value;

  modport source (
    output valid, command, plane_slot, first_x, first_y, first_z,
           second_x, second_y, second_z, scalar_value,
    input  ready
  );
  modport sink (
    input  valid, command, plane_slot, first_x, first_y, first_z,
           second_x, second_y, second_z, scalar_value,
    output ready
  );
endinterface

interface fvc_res_if;
  import fvc_pkg::*;
  logic             valid;
  logic             ready;
  logic [VIS_W-1:0] visibility;

  modport source (output valid, visibility, input ready);
  modport sink   (input valid, visibility, output ready);
endinterface

// ----- sv/fvc_mul.sv -----
// shared signed multiplier with floored fixed-point rescale and output register
module fvc_mul (
  input  logic           clk,
  input  logic           en,
  input  fvc_pkg::oper_t op_a,
  input  fvc_pkg::oper_t op_b,
  output fvc_pkg::acc_t  prod_r
);
  import fvc_pkg::*;

  logic signed [2*OP_W-1:0] full;

  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= ACC_W'(full >>> FRAC_BITS);
    end
  end
endmodule

// ----- sv/frustum_volume_culler_unit.sv -----
// top level: six-plane frustum culler with one shared multiply-accumulate unit
// A load transaction writes one plane (normal and offset) and gives no result; a slot
// beyond the plane count is dropped. A point, sphere or box test works through the
// planes in turn: every plane has a set-up state, a multiply and an accumulate state per
// product term (three for point and sphere, six for box) and a compare state, all
// through the single 33x33 multiplier. Ready returns in the same cycle that the result
// is offered. The block takes one test at a time; a finished result waits in the output
// register while the next command is accepted, and a test stalls only if it finishes
// before that result is taken. Planes reset to zero.
module frustum_volume_culler_unit (
  input  logic      clk,
  input  logic      rst_n,
  fvc_cmd_if.sink   in_ch,
  fvc_res_if.source out_ch
);
  import fvc_pkg::*;

  state_t state_r, state_nxt;

  coord_t nx_r  [PLANE_COUNT];
  coord_t ny_r  [PLANE_COUNT];
  coord_t nz_r  [PLANE_COUNT];
  coord_t off_r [PLANE_COUNT];

  oper_t  opa_r [AXES];
  oper_t  opb_r [AXES];
  acc_t   rad_init_r;
  acc_t   dist_r;
  acc_t   rad_r;
  logic   is_box_r;
  logic   inv_r;
  logic   full_r;
  logic [IDX_W-1:0]  plane_r;
  logic [TERM_W-1:0] term_r;
  logic              out_valid_r;
  logic [VIS_W-1:0]  vis_r;

  logic        in_acc;
  logic        is_load;
  logic        out_free;
  logic        res_load;
  logic        last_plane;
  logic        last_term;
  logic        inv_now;
  logic        part_now;
  logic [1:0]  axis;
  coord_t      n_sel;
  oper_t       n_op;
  oper_t       c_op;
  acc_t        prod;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign is_load          = (in_ch.command == CMD_LOAD);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.visibility = vis_r;
  assign out_free         = !out_valid_r || out_ch.ready;
  assign res_load         = (state_r == S_CMP) && last_plane && out_free;
  assign last_plane       = (plane_r == IDX_W'(PLANE_COUNT - 1));
  assign last_term        = (term_r == (is_box_r ? TERM_W'(5) : TERM_W'(2)));
  assign inv_now          = (dist_r < -rad_r);
  assign part_now         = !inv_now && (dist_r < rad_r);

  // operand selection for the shared multiplier
  always_comb begin
    axis = (term_r < TERM_W'(AXES)) ? term_r[1:0] : 2'(term_r - TERM_W'(AXES));
    case (axis)
      2'd0:    n_sel = nx_r[plane_r];
      2'd1:    n_sel = ny_r[plane_r];
      default: n_sel = nz_r[plane_r];
    endcase
    if (term_r < TERM_W'(AXES)) begin
      n_op = OP_W'(n_sel);
      c_op = opa_r[axis];
    end else begin
      n_op = (n_sel < 0) ? -OP_W'(n_sel) : OP_W'(n_sel);
      c_op = opb_r[axis];
    end
  end

  fvc_mul u_mul (
    .clk    (clk),
    .en     (state_r == S_MUL),
    .op_a   (n_op),
    .op_b   (c_op),
    .prod_r (prod)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && !is_load) state_nxt = S_INIT;
      S_INIT: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ADD;
      S_ADD:  state_nxt = last_term ? S_CMP : S_MUL;
      S_CMP: begin
        if (!last_plane) state_nxt = S_INIT;
        else if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      inv_r       <= 1'b0;
      full_r      <= 1'b1;
      plane_r     <= '0;
      term_r      <= '0;
      for (int i = 0; i < PLANE_COUNT; i++) begin
        nx_r[i]  <= '0;
        ny_r[i]  <= '0;
        nz_r[i]  <= '0;
        off_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (res_load) out_valid_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (is_load) begin
              if (32'(in_ch.plane_slot) < PLANE_COUNT) begin
                nx_r[IDX_W'(in_ch.plane_slot)]  <= in_ch.first_x;
                ny_r[IDX_W'(in_ch.plane_slot)]  <= in_ch.first_y;
                nz_r[IDX_W'(in_ch.plane_slot)]  <= in_ch.first_z;
                off_r[IDX_W'(in_ch.plane_slot)] <= in_ch.scalar_value;
              end
            end else begin
              is_box_r   <= (in_ch.command == CMD_BOX);
              rad_init_r <= (in_ch.command == CMD_SPHERE) ?
                            ACC_W'(in_ch.scalar_value) : '0;
              if (in_ch.command == CMD_BOX) begin
                opa_r[0] <= OP_W'(in_ch.first_x) + OP_W'(in_ch.second_x);
                opa_r[1] <= OP_W'(in_ch.first_y) + OP_W'(in_ch.second_y);
                opa_r[2] <= OP_W'(in_ch.first_z) + OP_W'(in_ch.second_z);
              end else begin
                opa_r[0] <= OP_W'(in_ch.first_x);
                opa_r[1] <= OP_W'(in_ch.first_y);
                opa_r[2] <= OP_W'(in_ch.first_z);
              end
              opb_r[0] <= OP_W'(in_ch.second_x) - OP_W'(in_ch.first_x);
              opb_r[1] <= OP_W'(in_ch.second_y) - OP_W'(in_ch.first_y);
              opb_r[2] <= OP_W'(in_ch.second_z) - OP_W'(in_ch.first_z);
              plane_r  <= '0;
              inv_r    <= 1'b0;
              full_r   <= 1'b1;
            end
          end
        end
        S_INIT: begin
          dist_r <= is_box_r ? (ACC_W'(off_r[plane_r]) <<< 1) : ACC_W'(off_r[plane_r]);
          rad_r  <= rad_init_r;
          term_r <= '0;
        end
        S_ADD: begin
          if (term_r < TERM_W'(AXES)) dist_r <= dist_r + prod;
          else rad_r <= rad_r + prod;
          term_r <= term_r + TERM_W'(1);
        end
        S_CMP: begin
          if (inv_now) inv_r <= 1'b1;
          else if (part_now) full_r <= 1'b0;
          if (!last_plane) begin
            plane_r <= plane_r + IDX_W'(1);
          end else if (out_free) begin
            if (inv_r || inv_now) vis_r <= VIS_INVISIBLE;
            else if (full_r && !part_now) vis_r <= VIS_FULL;
            else vis_r <= VIS_PARTIAL;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/fvc_chk.sv -----
// port-level checker for the frustum culler and its bind
module fvc_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [fvc_pkg::CMD_W-1:0] in_command,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [fvc_pkg::VIS_W-1:0] out_visibility
);
  import fvc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visibility))
    else $error("result dropped or changed while stalled");

  a_vis_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_visibility == VIS_INVISIBLE || out_visibility == VIS_PARTIAL ||
                   out_visibility == VIS_FULL))
    else $error("visibility code out of range");

  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command != CMD_LOAD |=> !in_ready)
    else $error("ready stayed high after a test transaction");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_LOAD |=> !$rose(out_valid))
    else $error("load transaction produced a result");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command != CMD_LOAD |=> ##1 !$rose(out_valid))
    else $error("test result appeared too early");
endmodule

bind frustum_volume_culler_unit fvc_chk u_fvc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_command     (in_ch.command),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_visibility (out_ch.visibility)
);

// ----- verif/fvc_visibility_checker.sv -----
// visibility predictor and result checker for the frustum volume culler
module fvc_visibility_checker
  import fvc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fvc_cmd_if   cmd_mon,
  fvc_res_if   res_mon,
  output int   mismatch_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_W+7:0]    wide_t;
  typedef logic signed [2*COORD_W+15:0] dist_t;

  coord_t           plane_nx [PLANE_COUNT];
  coord_t           plane_ny [PLANE_COUNT];
  coord_t           plane_nz [PLANE_COUNT];
  coord_t           plane_d  [PLANE_COUNT];
  logic [VIS_W-1:0] expected_vis_q [$];
  int               failures = 0;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // exact product, floored to the fixed-point grid
  function automatic dist_t floored_product(input wide_t n, input wide_t c);
    dist_t p;
    p = n * c;
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic [VIS_W-1:0] classify(input cmd_t op,
                                                input coord_t ax, ay, az, bx, by, bz,
                                                input coord_t radius);
    dist_t center_dist;
    dist_t reach;
    wide_t nx;
    wide_t ny;
    wide_t nz;
    logic  hidden;
    logic  clipped;
    hidden  = 1'b0;
    clipped = 1'b0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      nx = plane_nx[i];
      ny = plane_ny[i];
      nz = plane_nz[i];
      if (op == CMD_BOX) begin
        // doubled center distance and doubled projected radius
        center_dist = floored_product(nx, wide_t'(ax) + wide_t'(bx))
                    + floored_product(ny, wide_t'(ay) + wide_t'(by))
                    + floored_product(nz, wide_t'(az) + wide_t'(bz))
                    + (dist_t'(plane_d[i]) <<< 1);
        reach = floored_product((nx < 0) ? -nx : nx, wide_t'(bx) - wide_t'(ax))
              + floored_product((ny < 0) ? -ny : ny, wide_t'(by) - wide_t'(ay))
              + floored_product((nz < 0) ? -nz : nz, wide_t'(bz) - wide_t'(az));
      end else begin
        center_dist = floored_product(nx, ax) + floored_product(ny, ay)
                    + floored_product(nz, az) + dist_t'(plane_d[i]);
        if (op == CMD_SPHERE) begin
          reach = dist_t'(radius);
        end else begin
          reach = dist_t'(0);
        end
      end
      if (center_dist < -reach) begin
        hidden = 1'b1;
      end else if (center_dist < reach) begin
        clipped = 1'b1;
      end
    end
    if (hidden) begin
      return VIS_INVISIBLE;
    end else if (clipped) begin
      return VIS_PARTIAL;
    end
    return VIS_FULL;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        plane_nx[i] = '0;
        plane_ny[i] = '0;
        plane_nz[i] = '0;
        plane_d[i]  = '0;
      end
      expected_vis_q.delete();
      failures = 0;
    end else begin
      // results first: a transaction on the output always belongs to an older test
      if (res_mon.valid && res_mon.ready) begin
        if (expected_vis_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected result: expected none, actual %0d",
                   $time, res_mon.visibility);
        end else begin
          if (res_mon.visibility !== expected_vis_q[0]) begin
            failures++;
            $display("%0t: visibility mismatch: expected %0d, actual %0d",
                     $time, expected_vis_q[0], res_mon.visibility);
          end
          void'(expected_vis_q.pop_front());
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (cmd_t'(cmd_mon.command) == CMD_LOAD) begin
          if (cmd_mon.plane_slot < PLANE_COUNT) begin
            plane_nx[IDX_W'(cmd_mon.plane_slot)] = cmd_mon.first_x;
            plane_ny[IDX_W'(cmd_mon.plane_slot)] = cmd_mon.first_y;
            plane_nz[IDX_W'(cmd_mon.plane_slot)] = cmd_mon.first_z;
            plane_d[IDX_W'(cmd_mon.plane_slot)]  = cmd_mon.scalar_value;
          end
        end else begin
          expected_vis_q = {expected_vis_q,
                            classify(cmd_t'(cmd_mon.command),
                                     cmd_mon.first_x, cmd_mon.first_y,
                                     cmd_mon.first_z, cmd_mon.second_x,
                                     cmd_mon.second_y, cmd_mon.second_z,
                                     cmd_mon.scalar_value)};
        end
      end
    end
    mismatch_count <= failures;
    pending_count  <= expected_vis_q.size();
  end

endmodule

// ----- verif/tb_frustum_volume_culler_unit.sv -----
// testbench top: command stimulus, result back-pressure and verdict for the culler
module tb_frustum_volume_culler_unit import fvc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     TEST_COUNT   = 1350;
  localparam int     STALL_LIMIT  = 2000;
  localparam int     DRAIN_CYCLES = 100;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     FIX_ONE      = 65536;
  localparam coord_t ONE          = 32'sd65536;
  localparam coord_t CMIN         = 32'sh8000_0000;
  localparam coord_t CMAX         = 32'sh7fff_ffff;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

  typedef struct {
    cmd_t              op;
    logic [SLOT_W-1:0] slot;
    coord_t            fx, fy, fz;
    coord_t            sx, sy, sz;
    coord_t            scalar;
  } culler_cmd_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches;
  int   pending;
  int   burst_left  = 0;
  int   idle_cycles = 0;

  fvc_cmd_if in_ch ();
  fvc_res_if out_ch ();

  frustum_volume_culler_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fvc_visibility_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_mon        (in_ch),
    .res_mon        (out_ch),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic culler_cmd_t make_cmd(input cmd_t op, input int slot,
                                           input coord_t fx, fy, fz, sx, sy, sz,
                                           input coord_t scalar);
    culler_cmd_t c;
    c.op     = op;
    c.slot   = SLOT_W'(slot);
    c.fx     = fx;
    c.fy     = fy;
    c.fz     = fz;
    c.sx     = sx;
    c.sy     = sy;
    c.sz     = sz;
    c.scalar = scalar;
    return c;
  endfunction

  function automatic coord_t spread(input int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic coord_t noise();
    return coord_t'($urandom());
  endfunction

  function automatic culler_cmd_t random_cmd();
    culler_cmd_t c;
    coord_t      ex, ey, ez;
    coord_t      cx, cy, cz;
    c = make_cmd(cmd_t'($urandom_range(0, 3)), $urandom_range(0, PLANE_COUNT - 1),
                 noise(), noise(), noise(), noise(), noise(), noise(), noise());
    if ($urandom_range(0, 9) == 0) begin
      c.slot = SLOT_W'($urandom());
    end else begin
      if ($urandom_range(0, 11) == 0) begin
        c.slot = SLOT_W'($urandom_range(PLANE_COUNT, 7));
      end
      case (c.op)
        CMD_LOAD: begin
          // mostly planes facing the origin so that tests land on all outcomes
          c.fx = spread(FIX_ONE);
          c.fy = spread(FIX_ONE);
          c.fz = spread(FIX_ONE);
          if ($urandom_range(0, 4) == 0) begin
            c.scalar = spread(64 * FIX_ONE);
          end else begin
            c.scalar = coord_t'($urandom_range(16 * FIX_ONE, 64 * FIX_ONE));
          end
        end
        CMD_POINT: begin
          c.fx = spread(48 * FIX_ONE);
          c.fy = spread(48 * FIX_ONE);
          c.fz = spread(48 * FIX_ONE);
        end
        CMD_SPHERE: begin
          c.fx = spread(48 * FIX_ONE);
          c.fy = spread(48 * FIX_ONE);
          c.fz = spread(48 * FIX_ONE);
          if ($urandom_range(0, 6) == 0) begin
            c.scalar = -coord_t'($urandom_range(0, 4 * FIX_ONE));
          end else begin
            c.scalar = coord_t'($urandom_range(0, 16 * FIX_ONE));
          end
        end
        default: begin
          cx = spread(48 * FIX_ONE);
          cy = spread(48 * FIX_ONE);
          cz = spread(48 * FIX_ONE);
          ex = coord_t'($urandom_range(0, 8 * FIX_ONE));
          ey = coord_t'($urandom_range(0, 8 * FIX_ONE));
          ez = coord_t'($urandom_range(0, 8 * FIX_ONE));
          if ($urandom_range(0, 7) == 0) begin
            ex = -ex;
          end
          c.fx = cx - ex;
          c.fy = cy - ey;
          c.fz = cz - ez;
          c.sx = cx + ex;
          c.sy = cy + ey;
          c.sz = cz + ez;
        end
      endcase
    end
    return c;
  endfunction

  // one transaction, then the burst bookkeeping decides whether a gap follows
  task automatic issue_cmd(input culler_cmd_t c);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.command      <= c.op;
    in_ch.plane_slot   <= c.slot;
    in_ch.first_x      <= c.fx;
    in_ch.first_y      <= c.fy;
    in_ch.first_z      <= c.fz;
    in_ch.second_x     <= c.sx;
    in_ch.second_y     <= c.sy;
    in_ch.second_z     <= c.sz;
    in_ch.scalar_value <= c.scalar;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_LOAD;
    in_ch.plane_slot   <= '0;
    in_ch.first_x      <= '0;
    in_ch.first_y      <= '0;
    in_ch.first_z      <= '0;
    in_ch.second_x     <= '0;
    in_ch.second_y     <= '0;
    in_ch.second_z     <= '0;
    in_ch.scalar_value <= '0;
    burst_left = $urandom_range(1, 16);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // planes still at zero
    issue_cmd(make_cmd(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0));
    issue_cmd(make_cmd(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, -ONE));
    issue_cmd(make_cmd(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, ONE));
    issue_cmd(make_cmd(CMD_BOX, 0, 5 * ONE, 5 * ONE, 5 * ONE, -5 * ONE, -5 * ONE,
                       -5 * ONE, 0));
    // loads to slots past the plane count are dropped
    issue_cmd(make_cmd(CMD_LOAD, 7, ONE, ONE, ONE, 0, 0, 0, -ONE));
    issue_cmd(make_cmd(CMD_LOAD, PLANE_COUNT, -ONE, ONE, ONE, 0, 0, 0, -ONE));
    issue_cmd(make_cmd(CMD_POINT, 0, ONE, ONE, ONE, 0, 0, 0, 0));
    // extreme plane and operands
    issue_cmd(make_cmd(CMD_LOAD, 0, CMIN, CMAX, 0, 0, 0, 0, CMAX));
    issue_cmd(make_cmd(CMD_POINT, 0, CMAX, CMIN, -1, 0, 0, 0, 0));
    issue_cmd(make_cmd(CMD_POINT, 0, CMIN, CMAX, 0, 0, 0, 0, 0));
    issue_cmd(make_cmd(CMD_BOX, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0));
    issue_cmd(make_cmd(CMD_BOX, 0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0));
    issue_cmd(make_cmd(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, CMIN));
    issue_cmd(make_cmd(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, CMAX));
    // slab |x| <= 10 on the two outer slots
    issue_cmd(make_cmd(CMD_LOAD, 0, ONE, 0, 0, 0, 0, 0, 10 * ONE));
    issue_cmd(make_cmd(CMD_LOAD, PLANE_COUNT - 1, -ONE, 0, 0, 0, 0, 0, 10 * ONE));
    issue_cmd(make_cmd(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0));
    issue_cmd(make_cmd(CMD_POINT, 0, 11 * ONE, 0, 0, 0, 0, 0, 0));
    issue_cmd(make_cmd(CMD_SPHERE, 0, 9 * ONE, 0, 0, 0, 0, 0, 2 * ONE));
    issue_cmd(make_cmd(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, -ONE));
    issue_cmd(make_cmd(CMD_BOX, 0, -20 * ONE, 0, 0, 20 * ONE, 0, 0, 0));
    issue_cmd(make_cmd(CMD_LOAD, 3, CMIN, CMIN, CMIN, 0, 0, 0, CMIN));
    issue_cmd(make_cmd(CMD_BOX, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0));
    issue_cmd(make_cmd(CMD_POINT, 0, CMAX, CMAX, CMAX, 0, 0, 0, 0));

    repeat (TEST_COUNT) issue_cmd(random_cmd());
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result back-pressure: random segments plus two long hold-offs
  initial begin
    rx_mode_t mode;
    int       taken;
    int       seg_left;
    int       hold_left;
    int       last_hold;
    mode      = RX_OPEN;
    taken     = 0;
    seg_left  = 0;
    hold_left = 0;
    last_hold = -1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        taken++;
      end
      if (hold_left == 0 && (taken == 40 || taken == 400) && taken != last_hold) begin
        last_hold = taken;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 2));
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_CHOPPY: out_ch.ready <= 1'($urandom_range(0, 1));
          default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
